// ----- rtl/core/tlex_pkg.sv -----
// ---------------------------------------------------------------------------
// tlex_pkg: shared types and constants of the token lexer stream
// Character codes, token kinds, result record and output queue sizing.
// ---------------------------------------------------------------------------
package tlex_pkg;

   localparam int CHAR_W         = 8;
   localparam int VALUE_W        = 63;
   localparam int LEN_W          = 12;
   localparam int TOTAL_W        = 32;
   localparam int MAX_SYMBOL_LEN = 2048;
   localparam int SYM_CNT_W      = $clog2(MAX_SYMBOL_LEN + 1);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VALUE_W-1:0]   VALUE_MAX = {VALUE_W{1'b1}};
   localparam logic [TOTAL_W-1:0]   TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [SYM_CNT_W-1:0] SYM_MAX   = SYM_CNT_W'(MAX_SYMBOL_LEN);

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_Z   = 8'h7A;

   typedef enum logic [2:0] {
      KIND_INTEGER = 3'd0,
      KIND_OPEN    = 3'd1,
      KIND_CLOSE   = 3'd2,
      KIND_SYMCHAR = 3'd3,
      KIND_SYMEND  = 3'd4,
      KIND_ERROR   = 3'd5,
      KIND_DONE    = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [VALUE_W-1:0]    value;
      logic [LEN_W-1:0]      len;
      logic                  too_long;
      logic                  failed;
      logic                  last;
   } result_type;

   // up to two results per byte, already packed toward slot 0
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

// ----- rtl/core/token_lexer_stream_core.sv -----
// ---------------------------------------------------------------------------
// token_lexer_stream_core: streaming lexer, one source byte per transaction
// Turns a byte stream into integer, bracket, symbol, error and done tokens.
// ---------------------------------------------------------------------------
// Each result is registered in the result queue before it is offered on rsp_.
// Throughput: one byte per cycle while req_stall is low; a byte that closes a token and starts
//   another yields two result transactions, which leave the queue one at a time.
// req_stall rises when the four-entry result queue cannot take two more.
// Reset (synchronous, active high): lexer idle, counters zero, queue empty,
//   req_stall held high while reset is asserted.
module token_lexer_stream_core (
   input  logic                          clock,
   input  logic                          reset,
   // byte input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_char_code,
   // token output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_token_kind,
   output logic [62:0]                   rsp_value,
   output logic [11:0]                   rsp_symbol_length,
   output logic                          rsp_too_long,
   output logic                          rsp_failed,
   output logic                          rsp_last
);
   import tlex_pkg::*;

   logic       accept;
   logic       pop;
   logic       q_busy;
   push_type   push;
   result_type head;

   // a transaction on the input side is taken only with two queue slots free
   assign req_stall = reset || q_busy;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   // state update and token decision for the accepted byte
   tlex_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .push      (push)
   );

   // results wait here; the queue decouples rsp_stall from byte intake
   tlex_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .busy       (q_busy),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_token_kind    = head.kind;
   assign rsp_value         = head.value;
   assign rsp_symbol_length = head.len;
   assign rsp_too_long      = head.too_long;
   assign rsp_failed        = head.failed;
   assign rsp_last          = head.last;

endmodule

// ----- rtl/core/tlex_engine.sv -----
// ---------------------------------------------------------------------------
// tlex_engine: lexer state and per-byte token decision
// Classifies one byte, updates the lexer state, forms up to two results.
// ---------------------------------------------------------------------------
module tlex_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [tlex_pkg::CHAR_W-1:0]   char_code,
   output tlex_pkg::push_type            push
);
   import tlex_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_NUMBER = 4'b0010,
      MODE_SYMBOL = 4'b0100,
      MODE_FAILED = 4'b1000
   } mode_type;

   mode_type               mode_ff,  mode_in, mode_eff;
   logic [VALUE_W-1:0]     acc_ff,   acc_in;
   logic [SYM_CNT_W-1:0]   cnt_ff,   cnt_in;
   logic [TOTAL_W-1:0]     total_ff, total_in, total_a;
   logic                   ovf_ff,   ovf_in;

   logic                   is_dig, is_let, is_space, is_lead;
   logic [VALUE_W+3:0]     acc_wide;
   logic                   handled;
   logic                   a_vld, b_vld;
   result_type             res_a, res_b;

   assign is_dig   = char_code inside {[CH_ZERO:CH_NINE]};
   assign is_lead  = char_code inside {[CH_ONE:CH_NINE]};
   assign is_let   = char_code inside {[CH_UP_A:CH_UP_Z], [CH_LOW_A:CH_LOW_Z]};
   assign is_space = char_code inside {CH_SPACE, CH_TAB, CH_LF};

   // acc*10 + digit; anything above 63 bits means saturation
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                   + {{VALUE_W{1'b0}}, char_code[3:0]};

   always_comb begin
      mode_in  = mode_ff;
      mode_eff = mode_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      total_a  = total_ff;
      handled  = 1'b0;
      a_vld    = 1'b0;
      b_vld    = 1'b0;
      res_a    = '0;
      res_b    = '0;

      // first: continue or close a pending token
      case (mode_ff)
         MODE_NUMBER: begin
            if (is_dig) begin
               handled = 1'b1;
               if (acc_wide[VALUE_W+3:VALUE_W] != 4'b0) begin
                  acc_in = VALUE_MAX;
                  ovf_in = 1'b1;
               end else begin
                  acc_in = acc_wide[VALUE_W-1:0];
               end
            end else begin
               a_vld          = 1'b1;
               res_a.kind     = KIND_INTEGER;
               res_a.value    = acc_ff;
               res_a.too_long = ovf_ff;
               if (total_ff != TOTAL_MAX) total_a = total_ff + 1'b1;
               mode_eff = MODE_IDLE;
               acc_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         MODE_SYMBOL: begin
            if (is_let || is_dig) begin
               handled     = 1'b1;
               a_vld       = 1'b1;
               res_a.kind  = KIND_SYMCHAR;
               res_a.value = VALUE_W'(char_code);
               if (cnt_ff >= SYM_MAX) begin
                  cnt_in = SYM_MAX;
                  ovf_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               a_vld          = 1'b1;
               res_a.kind     = KIND_SYMEND;
               res_a.len      = LEN_W'(cnt_ff);
               res_a.too_long = ovf_ff;
               if (total_ff != TOTAL_MAX) total_a = total_ff + 1'b1;
               mode_eff = MODE_IDLE;
               cnt_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         default: ;
      endcase

      mode_in  = mode_eff;
      total_in = total_a;

      // second: end of text, or the byte as seen from idle
      if (!handled) begin
         if (char_code == CH_NUL) begin
            b_vld        = 1'b1;
            res_b.kind   = KIND_DONE;
            res_b.value  = VALUE_W'(total_a);
            res_b.failed = (mode_eff == MODE_FAILED);
            mode_in      = MODE_IDLE;
            acc_in       = '0;
            cnt_in       = '0;
            total_in     = '0;
            ovf_in       = 1'b0;
         end else if (mode_eff == MODE_IDLE) begin
            if (is_space) begin
               // separator only
            end else if (is_lead) begin
               mode_in = MODE_NUMBER;
               acc_in  = VALUE_W'(char_code[3:0]);
               ovf_in  = 1'b0;
            end else if (char_code == CH_OPEN || char_code == CH_CLOSE) begin
               b_vld      = 1'b1;
               res_b.kind = (char_code == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
               if (total_a != TOTAL_MAX) total_in = total_a + 1'b1;
            end else if (is_let) begin
               b_vld       = 1'b1;
               res_b.kind  = KIND_SYMCHAR;
               res_b.value = VALUE_W'(char_code);
               mode_in     = MODE_SYMBOL;
               cnt_in      = SYM_CNT_W'(1);
               ovf_in      = 1'b0;
            end else begin
               b_vld       = 1'b1;
               res_b.kind  = KIND_ERROR;
               res_b.value = VALUE_W'(char_code);
               mode_in     = MODE_FAILED;
            end
         end
      end

      // pack toward slot 0 and mark the final one
      res_a.last = !b_vld;
      res_b.last = 1'b1;
      push.push0 = accept && (a_vld || b_vld);
      push.push1 = accept && a_vld && b_vld;
      push.res0  = a_vld ? res_a : res_b;
      push.res1  = res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- rtl/core/tlex_queue.sv -----
// ---------------------------------------------------------------------------
// tlex_queue: result queue
// Shifting queue, two writes and one read per cycle; head sits in slot 0.
// ---------------------------------------------------------------------------
module tlex_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  tlex_pkg::push_type   push,
   input  logic                 pop,
   output logic                 busy,
   output logic                 head_valid,
   output tlex_pkg::result_type head
);
   import tlex_pkg::*;

   result_type           q_ff [QUEUE_DEPTH];
   result_type           q_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0]    cnt_ff, cnt_in, cnt_mid, cnt_mid1;

   always_comb begin
      q_in    = q_ff;
      cnt_mid = cnt_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_in[i] = q_ff[i + 1];
         cnt_mid = cnt_ff - 1'b1;
      end
      cnt_mid1 = cnt_mid + 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push.push0 && cnt_mid == QCNT_W'(i)) q_in[i] = push.res0;
         if (push.push1 && cnt_mid1 == QCNT_W'(i)) q_in[i] = push.res1;
      end
      cnt_in = cnt_mid + {{(QCNT_W-1){1'b0}}, push.push0}
                       + {{(QCNT_W-1){1'b0}}, push.push1};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // room for two more is required before a byte is taken
   assign busy       = cnt_ff > QCNT_W'(QUEUE_DEPTH - 2);
   assign head_valid = cnt_ff != '0;
   assign head       = q_ff[0];

endmodule

// ----- rtl/core/tlex_checker.sv -----
// ---------------------------------------------------------------------------
// tlex_checker: port-level checks of the token lexer stream
// Watches the top level ports; bound to token_lexer_stream_core by the bind below.
// ---------------------------------------------------------------------------
module tlex_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [7:0]                    req_char_code,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [2:0]                    rsp_token_kind,
   input  logic [62:0]                   rsp_value,
   input  logic [11:0]                   rsp_symbol_length,
   input  logic                          rsp_too_long,
   input  logic                          rsp_failed,
   input  logic                          rsp_last
);
   import tlex_pkg::*;

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_token_kind) && $stable(rsp_symbol_length)
         && $stable(rsp_too_long) && $stable(rsp_failed) && $stable(rsp_last))
      else $error("stalled result changed");

   // end of text always produces a result on the next cycle
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_char_code == CH_NUL |=> rsp_valid)
      else $error("no result after end byte");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_DONE |-> rsp_last)
      else $error("done not marked last");

   a_failed_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_token_kind == KIND_DONE)
      else $error("failed flag outside done");

   a_len_symend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_SYMEND |-> rsp_symbol_length == '0)
      else $error("length outside symbol end");

endmodule

bind token_lexer_stream_core tlex_checker u_checker (.*);
